// ----- design/ecpi_pkg.sv -----
// ============================================================================
// ecpi_pkg
// Shared widths, codes and types of the encoder speed PI controller.
// ============================================================================
package ecpi_pkg;

    localparam int CNT_W      = 32;
    localparam int RPM_W      = 16;
    localparam int DUTY_W     = 11;
    localparam int ELAPSED_W  = 10;
    localparam int PPR_W      = 16;
    localparam int GAIN_W     = 16;
    localparam int ILIM_W     = 18;
    localparam int INTEG_W    = 20;
    localparam int ERR_W      = RPM_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    localparam int NUM_W = 47;
    localparam int DEN_W = ELAPSED_W + PPR_W;
    localparam int P_W   = ERR_W + GAIN_W + 1;
    localparam int I_W   = INTEG_W + GAIN_W + 1;
    localparam int S_W   = I_W + 1;
    localparam int RQ_W  = S_W - 8;

    localparam int RPM_SCALE    = 60000;
    localparam int MAX_DUTY_DEF = 1023;
    localparam int QDEPTH       = 2;

    localparam logic signed [RPM_W-1:0] DEAD_HI = 16'sd10;
    localparam logic signed [RPM_W-1:0] DEAD_LO = -16'sd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PHASE_A_LEADS  = 3'd0,
        REG_PULSES_PER_REV = 3'd1,
        REG_TARGET_RPM     = 3'd2,
        REG_PROP_GAIN      = 3'd3,
        REG_INTEG_GAIN     = 3'd4,
        REG_INTEGRAL_LIMIT = 3'd5,
        REG_LOOP_ENABLE    = 3'd6,
        REG_MANUAL_DUTY    = 3'd7
    } t_cfg_reg;

    typedef enum logic [1:0] {
        OP_UP,
        OP_DOWN,
        OP_TICK
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ABS,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_ERR,
        ST_INTEG,
        ST_MULP,
        ST_MULI,
        ST_SUM,
        ST_RND,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                  phase_a_leads;
        logic [PPR_W-1:0]      pulses_per_rev;
        logic [RPM_W-1:0]      target_rpm;
        logic [GAIN_W-1:0]     prop_gain;
        logic [GAIN_W-1:0]     integ_gain;
        logic [ILIM_W-1:0]     integral_limit;
        logic                  loop_enable;
        logic [DUTY_W-1:0]     manual_duty;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        phase_a_leads:  1'b1,
        pulses_per_rev: 16'd1,
        target_rpm:     16'd0,
        prop_gain:      16'd768,
        integ_gain:     16'd256,
        integral_limit: 18'd1023,
        loop_enable:    1'b0,
        manual_duty:    11'd0
    };

    typedef struct packed {
        t_op                   op;
        logic [ELAPSED_W-1:0]  elapsed;
    } t_cmd;

    typedef struct packed {
        logic                  start;
        logic [NUM_W-1:0]      num;
        logic [DEN_W-1:0]      den;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [NUM_W-1:0]      quot;
    } t_div_rsp;

endpackage

// ----- design/ecpi_in_if.sv -----
// ============================================================================
// ecpi_in_if
// Input item channel: encoder edge events and speed ticks.
// ============================================================================
interface ecpi_in_if;
    import ecpi_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 req_type;
    logic                 phase_b_level;
    logic [ELAPSED_W-1:0] elapsed_ms;

    modport source (output valid, output req_type, output phase_b_level,
                    output elapsed_ms, input ready);
    modport sink   (input valid, input req_type, input phase_b_level,
                    input elapsed_ms, output ready);
endinterface

// ----- design/ecpi_out_if.sv -----
// ============================================================================
// ecpi_out_if
// Result item channel: count, speed, duty and update flag.
// ============================================================================
interface ecpi_out_if;
    import ecpi_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [CNT_W-1:0]  pulse_count;
    logic signed [RPM_W-1:0]  speed_rpm;
    logic signed [DUTY_W-1:0] duty;
    logic                     duty_updated;

    modport source (output valid, output pulse_count, output speed_rpm,
                    output duty, output duty_updated, input ready);
    modport sink   (input valid, input pulse_count, input speed_rpm,
                    input duty, input duty_updated, output ready);
endinterface

// ----- design/ecpi_front.sv -----
// ============================================================================
// ecpi_front
// Accepts input items, decodes them into count or tick commands and holds
// them in a short queue for the back end.
// ============================================================================
module ecpi_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_phase_a_leads,
    ecpi_in_if.sink          i_req,
    output logic             o_cmd_valid,
    output ecpi_pkg::t_cmd   o_cmd,
    input  logic             i_cmd_pop
);
    import ecpi_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNTQ_W = $clog2(QDEPTH + 1);

    t_cmd              r_q_mem [QDEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNTQ_W-1:0] r_count;
    logic              w_push;
    t_cmd              w_cmd;

    assign i_req.ready = (r_count != CNTQ_W'(QDEPTH));
    assign w_push      = i_req.valid && i_req.ready;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q_mem[r_rd_ptr];

    always_comb begin
        w_cmd.elapsed = i_req.elapsed_ms;
        priority if (i_req.req_type) begin
            w_cmd.op = OP_TICK;
        end else if (i_req.phase_b_level == i_phase_a_leads) begin
            w_cmd.op = OP_UP;
        end else begin
            w_cmd.op = OP_DOWN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_cmd_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !i_cmd_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_push && i_cmd_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q_mem[r_wr_ptr] <= w_cmd;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTQ_W'(QDEPTH))
        else $error("queue count beyond depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_pop |=> (r_count != CNTQ_W'(QDEPTH)) || $past(w_push))
        else $error("queue full after pop without push");

endmodule

// ----- design/ecpi_div.sv -----
// ============================================================================
// ecpi_div
// Radix-2 restoring divider, one quotient bit per cycle. A zero divisor
// yields a zero quotient.
// ============================================================================
module ecpi_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ecpi_pkg::t_div_req i_req,
    output ecpi_pkg::t_div_rsp o_rsp
);
    import ecpi_pkg::*;

    localparam int STEP_W = $clog2(NUM_W);

    logic [DEN_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_q;
    logic [DEN_W-1:0]  r_den;
    logic              r_zero;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;

    logic [DEN_W:0]    w_sh;
    logic [DEN_W:0]    w_diff;
    logic              w_ge;

    assign w_sh   = {r_rem, r_q[NUM_W-1]};
    assign w_diff = w_sh - {1'b0, r_den};
    assign w_ge   = (w_sh >= {1'b0, r_den});

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_zero ? '0 : r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= '0;
            r_q    <= i_req.num;
            r_den  <= i_req.den;
            r_zero <= (i_req.den == '0);
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_sh[DEN_W-1:0];
            r_q   <= {r_q[NUM_W-2:0], w_ge};
        end
    end

    a_no_early_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |=> !r_done)
        else $error("divider done right after start");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while busy");

endmodule

// ----- design/ecpi_back.sv -----
// ============================================================================
// ecpi_back
// Executes queued commands: edge counting, speed measurement, PI duty
// update and the registered result stage.
// ============================================================================
module ecpi_back #(
    parameter int MAX_DUTY = ecpi_pkg::MAX_DUTY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ecpi_pkg::t_cfg     i_cfg,
    input  logic               i_cfg_wr,
    input  logic               i_cmd_valid,
    input  ecpi_pkg::t_cmd     i_cmd,
    output logic               o_cmd_pop,
    output ecpi_pkg::t_div_req o_div_req,
    input  ecpi_pkg::t_div_rsp i_div_rsp,
    ecpi_out_if.source         o_rsp
);
    import ecpi_pkg::*;

    localparam logic signed [RQ_W-1:0] DUTY_HI = RQ_W'(MAX_DUTY);
    localparam logic signed [RQ_W-1:0] DUTY_LO = -DUTY_HI;
    localparam logic [NUM_W-1:0] POS_LIM = NUM_W'(32767);
    localparam logic [NUM_W-1:0] NEG_LIM = NUM_W'(32768);
    localparam logic [RPM_W-1:0] SCALE   = RPM_W'(RPM_SCALE);

    t_state r_state;
    t_state n_state;

    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     r_last;
    logic [RPM_W-1:0]     r_rpm;
    logic [INTEG_W-1:0]   r_integ;
    logic [DUTY_W-1:0]    r_duty;

    logic [CNT_W-1:0]     r_delta;
    logic [CNT_W-1:0]     r_dmag;
    logic                 r_neg;
    logic [ELAPSED_W-1:0] r_elapsed;
    logic [NUM_W-1:0]     r_num;
    logic [DEN_W-1:0]     r_den;
    logic [ERR_W-1:0]     r_err;
    logic [P_W-1:0]       r_pterm;
    logic [I_W-1:0]       r_iterm;
    logic [S_W-1:0]       r_sum;

    logic                 r_out_valid;
    logic [CNT_W-1:0]     r_out_count;
    logic [RPM_W-1:0]     r_out_rpm;
    logic [DUTY_W-1:0]    r_out_duty;
    logic                 r_out_upd;

    logic                 w_out_free;
    logic                 w_out_load;
    logic                 w_count_step;
    logic [CNT_W-1:0]     w_count_next;
    logic                 w_dead;
    logic                 w_pi_run;
    logic [RPM_W-1:0]     w_rpm_sat;
    logic [CNT_W+RPM_W-1:0]   w_num_prod;
    logic [DEN_W-1:0]         w_den_prod;
    logic signed [ERR_W-1:0]  w_err;
    logic signed [INTEG_W:0]  w_isum;
    logic signed [INTEG_W:0]  w_lim;
    logic signed [INTEG_W:0]  w_nlim;
    logic signed [INTEG_W:0]  w_iclamp;
    logic signed [P_W-1:0]    w_p;
    logic signed [I_W-1:0]    w_i;
    logic [S_W-1:0]           w_rnd;
    logic signed [RQ_W-1:0]   w_rq;
    logic signed [RQ_W-1:0]   w_man;
    logic signed [RQ_W-1:0]   w_duty_sat;
    logic signed [RQ_W-1:0]   w_man_sat;

    assign w_out_free   = !r_out_valid || o_rsp.ready;
    assign w_count_next = (i_cmd.op == OP_UP) ? r_count + 1'b1 : r_count - 1'b1;
    assign w_dead   = ($signed(i_cfg.target_rpm) < DEAD_HI) &&
                      ($signed(i_cfg.target_rpm) > DEAD_LO);
    assign w_pi_run = i_cfg.loop_enable && !w_dead;

    always_comb begin
        if (!r_neg) begin
            w_rpm_sat = (i_div_rsp.quot > POS_LIM) ? 16'h7FFF : i_div_rsp.quot[RPM_W-1:0];
        end else begin
            w_rpm_sat = (i_div_rsp.quot > NEG_LIM) ? 16'h8000
                                                   : ~i_div_rsp.quot[RPM_W-1:0] + 1'b1;
        end
    end

    assign w_num_prod = {{RPM_W{1'b0}}, r_dmag} * {{CNT_W{1'b0}}, SCALE};
    assign w_den_prod = {{PPR_W{1'b0}}, r_elapsed} * {{ELAPSED_W{1'b0}}, i_cfg.pulses_per_rev};

    assign w_err  = $signed({i_cfg.target_rpm[RPM_W-1], i_cfg.target_rpm})
                  - $signed({r_rpm[RPM_W-1], r_rpm});
    assign w_isum = $signed({r_integ[INTEG_W-1], r_integ})
                  + $signed({{(INTEG_W+1-ERR_W){r_err[ERR_W-1]}}, r_err});
    assign w_lim  = $signed({{(INTEG_W+1-ILIM_W){1'b0}}, i_cfg.integral_limit});
    assign w_nlim = -w_lim;

    always_comb begin
        priority if (w_isum > w_lim) begin
            w_iclamp = w_lim;
        end else if (w_isum < w_nlim) begin
            w_iclamp = w_nlim;
        end else begin
            w_iclamp = w_isum;
        end
    end

    assign w_p = $signed(r_err) * $signed({1'b0, i_cfg.prop_gain});
    assign w_i = $signed(r_integ) * $signed({1'b0, i_cfg.integ_gain});

    assign w_rnd = r_sum + (r_sum[S_W-1] ? S_W'(127) : S_W'(128));
    assign w_rq  = $signed(w_rnd[S_W-1:8]);
    assign w_man = $signed({{(RQ_W-DUTY_W){i_cfg.manual_duty[DUTY_W-1]}}, i_cfg.manual_duty});

    always_comb begin
        priority if (w_rq > DUTY_HI) begin
            w_duty_sat = DUTY_HI;
        end else if (w_rq < DUTY_LO) begin
            w_duty_sat = DUTY_LO;
        end else begin
            w_duty_sat = w_rq;
        end
        priority if (w_man > DUTY_HI) begin
            w_man_sat = DUTY_HI;
        end else if (w_man < DUTY_LO) begin
            w_man_sat = DUTY_LO;
        end else begin
            w_man_sat = w_man;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd_pop       = 1'b0;
        w_out_load      = 1'b0;
        w_count_step    = 1'b0;
        o_div_req.start = 1'b0;
        o_div_req.num   = r_num;
        o_div_req.den   = r_den;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.op == OP_TICK) begin
                        o_cmd_pop = 1'b1;
                        n_state   = ST_ABS;
                    end else if (w_out_free) begin
                        o_cmd_pop    = 1'b1;
                        w_count_step = 1'b1;
                        w_out_load   = 1'b1;
                    end
                end
            end
            ST_ABS:    n_state = ST_MUL;
            ST_MUL:    n_state = ST_DIV_GO;
            ST_DIV_GO: begin
                o_div_req.start = 1'b1;
                n_state         = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (i_div_rsp.done) begin
                    n_state = w_pi_run ? ST_ERR : ST_DONE;
                end
            end
            ST_ERR:    n_state = ST_INTEG;
            ST_INTEG:  n_state = ST_MULP;
            ST_MULP:   n_state = ST_MULI;
            ST_MULI:   n_state = ST_SUM;
            ST_SUM:    n_state = ST_RND;
            ST_RND:    n_state = ST_DONE;
            ST_DONE: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_last  <= '0;
            r_rpm   <= '0;
            r_integ <= '0;
            r_duty  <= '0;
        end else begin
            if (i_cfg_wr && !i_cfg.loop_enable) begin
                r_duty  <= w_man_sat[DUTY_W-1:0];
                r_integ <= '0;
            end
            if (w_count_step) begin
                r_count <= w_count_next;
            end
            if (r_state == ST_IDLE && o_cmd_pop && i_cmd.op == OP_TICK) begin
                r_last <= r_count;
            end
            if (r_state == ST_DIV_WAIT && i_div_rsp.done) begin
                r_rpm <= w_rpm_sat;
                if (i_cfg.loop_enable && w_dead) begin
                    r_duty <= '0;
                end
            end
            if (r_state == ST_INTEG) begin
                r_integ <= w_iclamp[INTEG_W-1:0];
            end
            if (r_state == ST_RND) begin
                r_duty <= w_duty_sat[DUTY_W-1:0];
            end
        end
    end

    // tick datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_delta   <= r_count - r_last;
                r_elapsed <= i_cmd.elapsed;
            end
            ST_ABS: begin
                r_neg  <= r_delta[CNT_W-1];
                r_dmag <= r_delta[CNT_W-1] ? ~r_delta + 1'b1 : r_delta;
            end
            ST_MUL: begin
                r_num <= w_num_prod[NUM_W-1:0];
                r_den <= w_den_prod;
            end
            ST_ERR:  r_err   <= w_err;
            ST_MULP: r_pterm <= w_p;
            ST_MULI: r_iterm <= w_i;
            ST_SUM: begin
                r_sum <= $signed({{(S_W-P_W){r_pterm[P_W-1]}}, r_pterm})
                       + $signed({{(S_W-I_W){r_iterm[I_W-1]}}, r_iterm});
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_count <= (r_state == ST_DONE) ? r_count : w_count_next;
            r_out_rpm   <= r_rpm;
            r_out_duty  <= r_duty;
            r_out_upd   <= (r_state == ST_DONE);
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.pulse_count  = $signed(r_out_count);
    assign o_rsp.speed_rpm    = $signed(r_out_rpm);
    assign o_rsp.duty         = $signed(r_out_duty);
    assign o_rsp.duty_updated = r_out_upd;

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (MAX_DUTY > 1023) ||
        (($signed(r_duty) <= MAX_DUTY) && ($signed(r_duty) >= -MAX_DUTY)))
        else $error("drive duty outside limit");

    a_integ_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_cfg.loop_enable && !i_cfg_wr) |-> (r_integ == '0))
        else $error("integral not cleared with loop off");

endmodule

// ----- design/encoder_speed_pi_controller.sv -----
// Event item: result registered after the queue stage, one event per cycle
//   sustained while the result side keeps up and no tick item is in progress.
// Tick item: states ABS, MUL, DIV_GO, DIV_WAIT, then with PI active ERR, INTEG,
//   MULP, MULI, SUM and RND, before DONE; DIV_WAIT waits on the 47-step radix-2 divider.
// Synchronous active-low reset clears counts, speed, integral and duty and
//   loads register defaults; no clearing pass.
// ============================================================================
// encoder_speed_pi_controller
// Quadrature encoder edge counter with rpm measurement and PI duty control.
// ============================================================================
module encoder_speed_pi_controller #(
    parameter int MAX_DUTY = ecpi_pkg::MAX_DUTY_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ecpi_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ecpi_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    ecpi_in_if.sink                           i_req,
    ecpi_out_if.source                        o_rsp
);
    import ecpi_pkg::*;

    t_cfg     r_cfg;
    logic     r_cfg_wr;
    logic     w_cmd_valid;
    t_cmd     w_cmd;
    logic     w_cmd_pop;
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg    <= CFG_RESET;
            r_cfg_wr <= 1'b0;
        end else begin
            r_cfg_wr <= i_cfg_we;
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_idx))
                    REG_PHASE_A_LEADS:  r_cfg.phase_a_leads  <= i_cfg_data[0];
                    REG_PULSES_PER_REV: r_cfg.pulses_per_rev <= i_cfg_data[PPR_W-1:0];
                    REG_TARGET_RPM:     r_cfg.target_rpm     <= i_cfg_data[RPM_W-1:0];
                    REG_PROP_GAIN:      r_cfg.prop_gain      <= i_cfg_data[GAIN_W-1:0];
                    REG_INTEG_GAIN:     r_cfg.integ_gain     <= i_cfg_data[GAIN_W-1:0];
                    REG_INTEGRAL_LIMIT: r_cfg.integral_limit <= i_cfg_data[ILIM_W-1:0];
                    REG_LOOP_ENABLE:    r_cfg.loop_enable    <= i_cfg_data[0];
                    REG_MANUAL_DUTY:    r_cfg.manual_duty    <= i_cfg_data[DUTY_W-1:0];
                endcase
            end
        end
    end

    ecpi_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_phase_a_leads (r_cfg.phase_a_leads),
        .i_req           (i_req),
        .o_cmd_valid     (w_cmd_valid),
        .o_cmd           (w_cmd),
        .i_cmd_pop       (w_cmd_pop)
    );

    ecpi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    ecpi_back #(
        .MAX_DUTY (MAX_DUTY)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cfg_wr    (r_cfg_wr),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_div_req   (w_div_req),
        .i_div_rsp   (w_div_rsp),
        .o_rsp       (o_rsp)
    );

endmodule

// ----- tb/tb_encoder_speed_pi_controller.sv -----
// ============================================================================
// tb_encoder_speed_pi_controller
// Self-checking bench for the encoder speed PI controller. Encoder edges and
// speed ticks are sent under random sender and receiver idling. A scoreboard
// computes the expected count, rpm and duty for every accepted item and
// compares each result item field by field.
// ============================================================================
module tb_encoder_speed_pi_controller;
    timeunit 1ns;
    timeprecision 1ps;

    import ecpi_pkg::*;

    localparam bit REQ_EDGE      = 1'b0;
    localparam bit REQ_TICK      = 1'b1;
    localparam int DUTY_LIMIT    = MAX_DUTY_DEF;
    localparam int DEAD_ZONE_RPM = 10;
    localparam int MS_PER_MIN    = 60000;
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES   = 400;
    localparam int PRINT_CAP     = 40;

    typedef struct {
        bit                   req_type;
        bit                   phase_b;
        bit [ELAPSED_W-1:0]   elapsed;
    } encoder_req_t;

    typedef struct {
        logic signed [CNT_W-1:0]  count;
        logic signed [RPM_W-1:0]  rpm;
        logic signed [DUTY_W-1:0] duty;
        logic                     updated;
    } speed_reading_t;

    class speed_pi_scoreboard;
        bit                     count_up_level;
        bit [PPR_W-1:0]         pulses_per_rev;
        bit signed [RPM_W-1:0]  target_rpm;
        bit [GAIN_W-1:0]        prop_gain;
        bit [GAIN_W-1:0]        integ_gain;
        bit [ILIM_W-1:0]        integ_limit;
        bit                     loop_on;
        bit signed [DUTY_W-1:0] manual_duty;
        bit [CNT_W-1:0]         edge_count;
        bit [CNT_W-1:0]         sampled_count;
        bit signed [RPM_W-1:0]  speed_rpm;
        longint                 integ_sum;
        bit signed [DUTY_W-1:0] drive_duty;
        speed_reading_t         readings_due[$];
        int                     errors;

        function new();
            count_up_level = 1'b1;
            pulses_per_rev = 1;
            target_rpm     = 0;
            prop_gain      = 768;
            integ_gain     = 256;
            integ_limit    = 1023;
            loop_on        = 1'b0;
            manual_duty    = 0;
            edge_count     = 0;
            sampled_count  = 0;
            speed_rpm      = 0;
            integ_sum      = 0;
            drive_duty     = 0;
            errors         = 0;
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function void follow_manual();
            if (!loop_on) begin
                drive_duty = DUTY_W'(clamp(manual_duty, -DUTY_LIMIT, DUTY_LIMIT));
                integ_sum  = 0;
            end
        endfunction

        function void apply_cfg(t_cfg_reg idx, bit [CFG_DATA_W-1:0] v);
            case (idx)
                REG_PHASE_A_LEADS:  count_up_level = v[0];
                REG_PULSES_PER_REV: pulses_per_rev = v[PPR_W-1:0];
                REG_TARGET_RPM:     target_rpm     = v[RPM_W-1:0];
                REG_PROP_GAIN:      prop_gain      = v[GAIN_W-1:0];
                REG_INTEG_GAIN:     integ_gain     = v[GAIN_W-1:0];
                REG_INTEGRAL_LIMIT: integ_limit    = v[ILIM_W-1:0];
                REG_LOOP_ENABLE:    loop_on        = v[0];
                REG_MANUAL_DUTY:    manual_duty    = v[DUTY_W-1:0];
            endcase
            follow_manual();
        endfunction

        function void note_item(encoder_req_t r);
            bit signed [CNT_W-1:0] diff;
            longint                delta;
            longint                den;
            longint                quot;
            longint                err;
            longint                s;
            longint                rounded;
            speed_reading_t        e;
            follow_manual();
            if (r.req_type == REQ_EDGE) begin
                if (r.phase_b == count_up_level) edge_count++;
                else edge_count--;
            end else begin
                diff  = edge_count - sampled_count;
                delta = diff;
                den   = longint'(r.elapsed) * longint'(pulses_per_rev);
                quot  = (den != 0) ? (delta * MS_PER_MIN) / den : 0;
                speed_rpm     = RPM_W'(clamp(quot, -32768, 32767));
                sampled_count = edge_count;
                if (loop_on) begin
                    if (target_rpm < DEAD_ZONE_RPM && target_rpm > -DEAD_ZONE_RPM) begin
                        drive_duty = '0;
                    end else begin
                        err       = longint'(target_rpm) - longint'(speed_rpm);
                        integ_sum = clamp(integ_sum + err, -longint'(integ_limit),
                                          longint'(integ_limit));
                        s = longint'(prop_gain) * err + longint'(integ_gain) * integ_sum;
                        rounded    = (s >= 0) ? (s + 128) / 256 : -((128 - s) / 256);
                        drive_duty = DUTY_W'(clamp(rounded, -DUTY_LIMIT, DUTY_LIMIT));
                    end
                end
            end
            e.count   = edge_count;
            e.rpm     = speed_rpm;
            e.duty    = drive_duty;
            e.updated = (r.req_type == REQ_TICK);
            readings_due.push_back(e);
        endfunction

        function int pending();
            return readings_due.size();
        endfunction

        function void report(string field, longint want, longint got);
            errors++;
            if (errors <= PRINT_CAP)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        endfunction

        function void check_result(speed_reading_t got);
            speed_reading_t want;
            if (readings_due.size() == 0) begin
                errors++;
                if (errors <= PRINT_CAP)
                    $display("%0t: unexpected result item, expected none, got count %0d",
                             $time, got.count);
                return;
            end
            want = readings_due.pop_front();
            if (got.count !== want.count) report("pulse_count", want.count, got.count);
            if (got.rpm !== want.rpm) report("speed_rpm", want.rpm, got.rpm);
            if (got.duty !== want.duty) report("duty", want.duty, got.duty);
            if (got.updated !== want.updated) report("duty_updated", want.updated, got.updated);
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ecpi_in_if  req_if ();
    ecpi_out_if rsp_if ();

    speed_pi_scoreboard book = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int holds_served  = 0;

    encoder_speed_pi_controller i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("encoder_speed_pi_controller test failed");
        $finish;
    end

    initial begin : result_sink
        int             hold_left;
        speed_reading_t got;
        hold_left = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
                got.count   = rsp_if.pulse_count;
                got.rpm     = rsp_if.speed_rpm;
                got.duty    = rsp_if.duty;
                got.updated = rsp_if.duty_updated;
                book.check_result(got);
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_item(bit kind, bit level, bit [ELAPSED_W-1:0] el);
        encoder_req_t r;
        int           gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        r.req_type = kind;
        r.phase_b  = level;
        r.elapsed  = el;
        req_if.valid         <= 1'b1;
        req_if.req_type      <= kind;
        req_if.phase_b_level <= level;
        req_if.elapsed_ms    <= el;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        book.note_item(r);
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        while (book.pending() > 0) @(posedge i_clk);
    endtask

    task automatic write_cfg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        book.apply_cfg(idx, v);
    endtask

    function automatic bit [GAIN_W-1:0] pick_gain();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10) return '0;
        if (roll < 20) return '1;
        return GAIN_W'($urandom_range(1024));
    endfunction

    task automatic randomize_setup();
        t_cfg_reg              order [8];
        t_cfg_reg              swap;
        logic [CFG_DATA_W-1:0] v;
        bit [GAIN_W-1:0]       ki;
        int                    j;
        int                    roll;
        int                    t;
        for (int i = 0; i < 8; i++) order[i] = t_cfg_reg'(i);
        for (int i = 7; i > 0; i--) begin
            j        = $urandom_range(i);
            swap     = order[i];
            order[i] = order[j];
            order[j] = swap;
        end
        ki = pick_gain();
        for (int i = 0; i < 8; i++) begin
            v    = CFG_DATA_W'($urandom);
            roll = $urandom_range(99);
            case (order[i])
                REG_PHASE_A_LEADS: ;
                REG_LOOP_ENABLE:   v[0] = (roll < 75);
                REG_PULSES_PER_REV: begin
                    if (roll < 5) t = 0;
                    else if (roll < 12) t = 65535;
                    else if (roll < 20) t = 1;
                    else t = $urandom_range(400, 2);
                    v[PPR_W-1:0] = PPR_W'(t);
                end
                REG_TARGET_RPM: begin
                    if (roll < 15) t = int'($urandom_range(18)) - 9;
                    else if (roll < 20) t = 32767;
                    else if (roll < 25) t = -32768;
                    else if (roll < 30) t = 10;
                    else if (roll < 35) t = -10;
                    else t = int'($urandom_range(6000)) - 3000;
                    v[RPM_W-1:0] = RPM_W'(t);
                end
                REG_PROP_GAIN:  v[GAIN_W-1:0] = pick_gain();
                REG_INTEG_GAIN: v[GAIN_W-1:0] = ki;
                REG_INTEGRAL_LIMIT: begin
                    if (roll < 10) t = 0;
                    else if (roll < 20) t = 262143;
                    else if (roll < 30 || ki == 0) t = $urandom_range(262143);
                    else t = (DUTY_LIMIT * 256 + int'(ki) - 1) / int'(ki);
                    v[ILIM_W-1:0] = ILIM_W'(t);
                end
                REG_MANUAL_DUTY: begin
                    if (roll < 10) v[DUTY_W-1:0] = DUTY_W'(-1024);
                    else if (roll < 20) v[DUTY_W-1:0] = DUTY_W'(DUTY_LIMIT);
                    else if (roll < 30) v[DUTY_W-1:0] = DUTY_W'(-DUTY_LIMIT);
                end
            endcase
            write_cfg(order[i], v);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_block(int quota);
        int                 sent;
        int                 run_len;
        int                 roll;
        bit                 fwd;
        bit [ELAPSED_W-1:0] el;
        sent = 0;
        while (sent < quota) begin
            fwd     = $urandom_range(1);
            run_len = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(12);
            for (int k = 0; k < run_len && sent < quota; k++) begin
                send_item(REQ_EDGE, ($urandom_range(99) < 88) ? fwd : !fwd,
                          ELAPSED_W'($urandom));
                sent++;
            end
            roll = $urandom_range(99);
            if (roll < 60) el = ELAPSED_W'($urandom_range(100, 20));
            else if (roll < 70) el = 1;
            else if (roll < 78) el = '1;
            else if (roll < 83) el = '0;
            else el = ELAPSED_W'($urandom);
            send_item(REQ_TICK, $urandom_range(1), el);
            sent++;
        end
    endtask

    initial begin : stimulus
        i_rst_n              <= 1'b0;
        i_cfg_we             <= 1'b0;
        i_cfg_idx            <= REG_PHASE_A_LEADS;
        i_cfg_data           <= '0;
        req_if.valid         <= 1'b0;
        req_if.req_type      <= REQ_EDGE;
        req_if.phase_b_level <= 1'b0;
        req_if.elapsed_ms    <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset setup: loop off, B high counts up
        send_item(REQ_EDGE, 1'b1, '0);
        send_item(REQ_EDGE, 1'b1, '0);
        send_item(REQ_EDGE, 1'b0, '0);
        send_item(REQ_TICK, 1'b0, 1);
        send_item(REQ_EDGE, 1'b0, '0);
        send_item(REQ_EDGE, 1'b0, '0);
        send_item(REQ_EDGE, 1'b0, '0);
        send_item(REQ_TICK, 1'b1, '1);
        send_item(REQ_TICK, 1'b0, '0);
        drain();

        // reversed direction, zero pulses per rev, most negative manual duty
        write_cfg(REG_PHASE_A_LEADS, '0);
        write_cfg(REG_PULSES_PER_REV, '0);
        write_cfg(REG_MANUAL_DUTY, CFG_DATA_W'(-1024));
        i_cfg_we <= 1'b0;
        send_item(REQ_EDGE, 1'b0, '0);
        send_item(REQ_TICK, 1'b0, 50);
        drain();

        // half-way rounding in both directions
        write_cfg(REG_PULSES_PER_REV, 1);
        write_cfg(REG_PROP_GAIN, 128);
        write_cfg(REG_INTEG_GAIN, '0);
        write_cfg(REG_INTEGRAL_LIMIT, '0);
        write_cfg(REG_TARGET_RPM, 11);
        write_cfg(REG_LOOP_ENABLE, 1);
        i_cfg_we <= 1'b0;
        send_item(REQ_TICK, 1'b0, '0);
        drain();
        write_cfg(REG_TARGET_RPM, CFG_DATA_W'(-11));
        i_cfg_we <= 1'b0;
        send_item(REQ_TICK, 1'b0, '0);
        drain();

        // dead zone, then its edge
        write_cfg(REG_TARGET_RPM, 9);
        i_cfg_we <= 1'b0;
        send_item(REQ_EDGE, 1'b1, '0);
        send_item(REQ_TICK, 1'b0, '0);
        drain();
        write_cfg(REG_TARGET_RPM, CFG_DATA_W'(-10));
        write_cfg(REG_PROP_GAIN, 768);
        write_cfg(REG_INTEG_GAIN, 256);
        write_cfg(REG_INTEGRAL_LIMIT, 1023);
        i_cfg_we <= 1'b0;
        send_item(REQ_TICK, 1'b0, '0);
        send_item(REQ_TICK, 1'b1, '0);
        drain();

        // saturation at both ends with the largest gains and limit
        write_cfg(REG_TARGET_RPM, 32767);
        write_cfg(REG_PROP_GAIN, 16'hFFFF);
        write_cfg(REG_INTEG_GAIN, 16'hFFFF);
        write_cfg(REG_INTEGRAL_LIMIT, 18'h3FFFF);
        i_cfg_we <= 1'b0;
        send_item(REQ_TICK, 1'b0, '0);
        send_item(REQ_TICK, 1'b0, '0);
        drain();
        write_cfg(REG_TARGET_RPM, CFG_DATA_W'(-32768));
        i_cfg_we <= 1'b0;
        send_item(REQ_TICK, 1'b0, '0);
        drain();
        write_cfg(REG_INTEGRAL_LIMIT, '0);
        write_cfg(REG_PULSES_PER_REV, 16'hFFFF);
        i_cfg_we <= 1'b0;
        send_item(REQ_EDGE, 1'b1, '0);
        send_item(REQ_TICK, 1'b0, 1);
        drain();

        // back to manual duty at both limits
        write_cfg(REG_LOOP_ENABLE, '0);
        write_cfg(REG_MANUAL_DUTY, DUTY_LIMIT);
        i_cfg_we <= 1'b0;
        send_item(REQ_TICK, 1'b0, 50);
        drain();
        write_cfg(REG_MANUAL_DUTY, CFG_DATA_W'(-DUTY_LIMIT));
        i_cfg_we <= 1'b0;
        send_item(REQ_EDGE, 1'b0, '0);

        for (int p = 0; p < 3; p++) begin
            send_idle_pct = (p == 0) ? 26 : ((p == 1) ? 65 : 0);
            recv_idle_pct = (p == 0) ? 65 : ((p == 1) ? 26 : 0);
            for (int b = 0; b < 6; b++) begin
                drain();
                randomize_setup();
                if (p == 2 && b == 1) hold_requests++;
                run_block(50);
            end
        end
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (book.errors == 0 && book.pending() == 0) begin
            $display("encoder_speed_pi_controller test passed");
        end else begin
            $display("encoder_speed_pi_controller test failed");
        end
        $finish;
    end

endmodule

// ----- encoder_speed_pi_controller.f -----
design/ecpi_pkg.sv
design/ecpi_in_if.sv
design/ecpi_out_if.sv
design/ecpi_front.sv
design/ecpi_div.sv
design/ecpi_back.sv
design/encoder_speed_pi_controller.sv
tb/tb_encoder_speed_pi_controller.sv
